// ===== sv/obls_pkg.sv =====
// ----------------------------------------------------------------------------
// obls_pkg: shared types and codes for the ordered byte list store
// Operation and status codes, cell command bundle and control state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package obls_pkg;

    // Default list size (number of cells)
    localparam int CAPACITY_DEF = 16;

    // Field widths
    localparam int OP_W     = 2;
    localparam int DATA_W   = 8;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;
    localparam int OUT_TDATA_W = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE  = 2'd1;
    localparam logic [OP_W-1:0] OP_DISPLAY = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic              append;
        logic              delete;
        logic              rotate;
        logic [DATA_W-1:0] value;
    } t_cell_cmd;

    // Control state, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DISP = 2'b10
    } t_state;

endpackage

`default_nettype wire

// ===== sv/ordered_byte_list_store_core.sv =====
// ----------------------------------------------------------------------------
// ordered_byte_list_store_core: ordered list of bytes in a row of cells
// Append, delete-first-match and display over a list held head to tail.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: tuser carries the operation (append, delete, display),
//   tdata the byte. Master channel: tuser carries the status, tdata the
//   displayed byte and the list length, tlast marks the final transfer
//   caused by one input transfer.
//   Append and delete finish in the cycle of the input transfer; their one
//   result sits in the output register on the next cycle. Display on a
//   non-empty list enters the display state and then streams 2*length
//   results, one per cycle while the receiver takes them, by rotating the
//   cell row so that the head cell always holds the next byte; the ring is
//   back in place after two turns.
//   Input is taken only between items and while the output register is
//   free or being drained. When the receiver stalls, the output register
//   holds its transfer and the row stops rotating.
//   Reset clears the length and the output register; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_byte_list_store_core #(
    parameter int CAPACITY = obls_pkg::CAPACITY_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire  [obls_pkg::DATA_W-1:0]       s_axis_tdata,   // [7:0] value
    input  wire  [obls_pkg::OP_W-1:0]         s_axis_tuser,   // [1:0] operation
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [obls_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // [7:0] data, [12:8] length
    output logic [obls_pkg::STATUS_W-1:0]     m_axis_tuser,   // [1:0] status
    output logic                              m_axis_tlast
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int REM_W = $clog2(2 * CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    obls_pkg::t_state    r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic                r_out_valid, n_out_valid;
    logic [obls_pkg::STATUS_W-1:0] r_status, n_status;
    logic [obls_pkg::DATA_W-1:0]   r_data, n_data;
    logic [obls_pkg::LEN_W-1:0]    r_len, n_len;
    logic                r_last, n_last;

    logic                w_in_fire;
    logic                w_out_free;
    logic                w_found;
    obls_pkg::t_cell_cmd w_cmd;
    logic [obls_pkg::DATA_W-1:0] w_cell_data [CAPACITY];
    logic                w_hit [CAPACITY+1];

    // Handshake
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == obls_pkg::S_IDLE) && w_out_free;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    // Broadcast command to the cell row
    assign w_cmd.append = w_in_fire && (s_axis_tuser == obls_pkg::OP_APPEND)
                          && (r_count < CAP_CNT);
    assign w_cmd.delete = w_in_fire && (s_axis_tuser == obls_pkg::OP_DELETE);
    assign w_cmd.rotate = (r_state == obls_pkg::S_DISP) && w_out_free;
    assign w_cmd.value  = s_axis_tdata;

    // Cell row, head at cell 0
    assign w_hit[0] = 1'b0;

    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            logic [obls_pkg::DATA_W-1:0] w_next;
            if (g == CAPACITY - 1) begin : g_end
                assign w_next = w_cell_data[g];
            end else begin : g_mid
                assign w_next = w_cell_data[g+1];
            end
            obls_cell #(
                .IDX   (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .i_clk       (i_clk),
                .i_cmd       (w_cmd),
                .i_count     (r_count),
                .i_next_data (w_next),
                .i_head_data (w_cell_data[0]),
                .i_hit       (w_hit[g]),
                .o_data      (w_cell_data[g]),
                .o_hit       (w_hit[g+1])
            );
        end
    endgenerate

    assign w_found = w_hit[CAPACITY];

    // Sequence operations and fill the output register
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rem       = r_rem;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_data      = r_data;
        n_len       = r_len;
        n_last      = r_last;

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            obls_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    n_out_valid = 1'b1;
                    n_status    = obls_pkg::ST_DONE;
                    n_data      = '0;
                    n_last      = 1'b1;
                    unique case (s_axis_tuser)
                        obls_pkg::OP_APPEND: begin
                            if (r_count < CAP_CNT) begin
                                n_count = r_count + CNT_W'(1);
                            end else begin
                                n_status = obls_pkg::ST_FULL;
                            end
                        end
                        obls_pkg::OP_DELETE: begin
                            if (w_found) begin
                                n_count = r_count - CNT_W'(1);
                            end else begin
                                n_status = obls_pkg::ST_NOTFOUND;
                            end
                        end
                        obls_pkg::OP_DISPLAY: begin
                            if (r_count == '0) begin
                                n_status = obls_pkg::ST_EMPTY;
                            end else begin
                                // Hold off output; stream from the display state
                                n_out_valid = 1'b0;
                                n_rem       = REM_W'(r_count) << 1;
                                n_state     = obls_pkg::S_DISP;
                            end
                        end
                        default: begin
                            // Unused code: no change, plain done
                        end
                    endcase
                    n_len = obls_pkg::LEN_W'(n_count);
                end
            end
            obls_pkg::S_DISP: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = obls_pkg::ST_DONE;
                    n_data      = w_cell_data[0];
                    n_len       = obls_pkg::LEN_W'(r_count);
                    n_last      = (r_rem == REM_W'(1));
                    n_rem       = r_rem - REM_W'(1);
                    if (r_rem == REM_W'(1)) begin
                        n_state = obls_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = obls_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= obls_pkg::S_IDLE;
            r_count     <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rem       <= n_rem;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_data   <= n_data;
        r_len    <= n_len;
        r_last   <= n_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {{(obls_pkg::OUT_TDATA_W - obls_pkg::LEN_W - obls_pkg::DATA_W){1'b0}},
                            r_len, r_data};

endmodule

`default_nettype wire

// ===== sv/obls_cell.sv =====
// ----------------------------------------------------------------------------
// obls_cell: one byte slot of the list
// Holds one byte, matches it against the delete value, passes the match
// flag on toward the tail and takes its neighbor's byte on a shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obls_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  wire                         i_clk,
    input  wire  obls_pkg::t_cell_cmd   i_cmd,
    input  wire  [CNT_W-1:0]            i_count,
    input  wire  [obls_pkg::DATA_W-1:0] i_next_data,
    input  wire  [obls_pkg::DATA_W-1:0] i_head_data,
    input  wire                         i_hit,
    output logic [obls_pkg::DATA_W-1:0] o_data,
    output logic                        o_hit
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [obls_pkg::DATA_W-1:0] r_data;
    logic [obls_pkg::DATA_W-1:0] n_data;
    logic                        w_valid;
    logic                        w_match;
    logic                        w_is_tail;

    // Match only on occupied slots; pass the first-match flag down the row
    assign w_valid   = (MY_IDX < i_count);
    assign w_match   = w_valid && (r_data == i_cmd.value);
    assign o_hit     = i_hit | w_match;
    assign w_is_tail = (MY_IDX == (i_count - CNT_W'(1)));

    // Select next byte: append at the tail, close the gap, or rotate the ring
    always_comb begin
        n_data = r_data;
        if (i_cmd.append && (MY_IDX == i_count)) begin
            n_data = i_cmd.value;
        end else if (i_cmd.delete && o_hit) begin
            n_data = i_next_data;
        end else if (i_cmd.rotate) begin
            n_data = w_is_tail ? i_head_data : i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for ordered_byte_list_store_core
// Drives append, delete and display transfers with random gaps and output
// stalls, keeps a shadow copy of the byte list to predict every reply, and
// compares each output transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int                        LIST_CAP    = obls_pkg::CAPACITY_DEF;
    localparam logic [obls_pkg::OP_W-1:0] OP_UNUSED   = 2'd3;
    localparam int                        HOLD_CYCLES = 90;
    localparam int                        DRAIN_WAIT  = 2 * LIST_CAP + 8;

    // One reply as seen on the master channel
    typedef struct packed {
        logic [obls_pkg::STATUS_W-1:0] status;
        logic [obls_pkg::DATA_W-1:0]   data;
        logic [obls_pkg::LEN_W-1:0]    length;
        logic                          last;
    } t_reply;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_tvalid;
    wire                              s_tready;
    logic [obls_pkg::DATA_W-1:0]      s_tdata;
    logic [obls_pkg::OP_W-1:0]        s_tuser;
    wire                              m_tvalid;
    logic                             m_tready;
    wire  [obls_pkg::OUT_TDATA_W-1:0] m_tdata;
    wire  [obls_pkg::STATUS_W-1:0]    m_tuser;
    wire                              m_tlast;

    logic [obls_pkg::DATA_W-1:0] shadow_list[$];     // predicted list, head at index 0
    t_reply                      awaited_replies[$]; // replies still to come, oldest first
    int                          fail_count;
    logic                        gaps_on;
    int                          stall_requests;
    int                          stall_served;
    int                          stall_left;

    ordered_byte_list_store_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),   // [7:0] value
        .s_axis_tuser  (s_tuser),   // [1:0] operation
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),   // [7:0] data, [12:8] length
        .m_axis_tuser  (m_tuser),   // [1:0] status
        .m_axis_tlast  (m_tlast)
    );

    // Free-running clock, 4 ns period
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Queue one reply with the current list length
    function automatic void push_reply(logic [obls_pkg::STATUS_W-1:0] status,
                                       logic [obls_pkg::DATA_W-1:0] data, logic last);
        t_reply r;
        r.status = status;
        r.data   = data;
        r.length = obls_pkg::LEN_W'(shadow_list.size());
        r.last   = last;
        awaited_replies.push_back(r);
    endfunction

    // Apply one accepted operation to the shadow list and queue its replies
    function automatic void apply_list_op(logic [obls_pkg::OP_W-1:0] op,
                                          logic [obls_pkg::DATA_W-1:0] val);
        int pos;
        int n;
        pos = -1;
        n   = shadow_list.size();
        case (op)
            obls_pkg::OP_APPEND: begin
                if (n >= LIST_CAP) begin
                    push_reply(obls_pkg::ST_FULL, '0, 1'b1);
                end else begin
                    shadow_list.push_back(val);
                    push_reply(obls_pkg::ST_DONE, '0, 1'b1);
                end
            end
            obls_pkg::OP_DELETE: begin
                for (int i = 0; i < n; i++) begin
                    if (pos < 0 && shadow_list[i] == val) pos = i;
                end
                if (pos < 0) begin
                    push_reply(obls_pkg::ST_NOTFOUND, '0, 1'b1);
                end else begin
                    shadow_list.delete(pos);
                    push_reply(obls_pkg::ST_DONE, '0, 1'b1);
                end
            end
            obls_pkg::OP_DISPLAY: begin
                if (n == 0) begin
                    push_reply(obls_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    // walk the ring twice from the head
                    for (int k = 0; k < 2 * n; k++)
                        push_reply(obls_pkg::ST_DONE, shadow_list[k % n], k == 2 * n - 1);
                end
            end
            default: begin
                push_reply(obls_pkg::ST_DONE, '0, 1'b1);
            end
        endcase
    endfunction

    // Offer one item, hold it until the transfer, then predict its replies
    task automatic send_item(input logic [obls_pkg::OP_W-1:0] op,
                             input logic [obls_pkg::DATA_W-1:0] val);
        while (gaps_on && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        do @(posedge i_clk); while (!s_tready);
        apply_list_op(op, val);
    endtask

    // Draw one random item; append_pct steers the list toward full or empty
    task automatic send_random_item(input int append_pct);
        int                          r;
        logic [obls_pkg::OP_W-1:0]   op;
        logic [obls_pkg::DATA_W-1:0] val;
        r   = $urandom_range(0, 99);
        val = obls_pkg::DATA_W'($urandom_range(0, 255));
        if (r < append_pct) begin
            op = obls_pkg::OP_APPEND;
            // a narrow value range gives duplicates for the first-match rule
            if ($urandom_range(0, 99) < 40) val = obls_pkg::DATA_W'($urandom_range(0, 7));
        end else if (r < 88) begin
            op = obls_pkg::OP_DELETE;
            if (shadow_list.size() > 0 && $urandom_range(0, 99) < 75)
                val = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
        end else if (r < 97) begin
            op = obls_pkg::OP_DISPLAY;
        end else begin
            op = OP_UNUSED;
        end
        send_item(op, val);
    endtask

    // Display, delete and unused code on an empty list
    task automatic test_empty_list();
        send_item(obls_pkg::OP_DISPLAY, 8'h00);
        send_item(obls_pkg::OP_DELETE, 8'h00);
        send_item(OP_UNUSED, 8'hAB);
    endtask

    // Fill to capacity with extremes and duplicates, overflow once, show it
    task automatic test_fill_to_full();
        logic [obls_pkg::DATA_W-1:0] fill_vals[LIST_CAP] = '{8'h00, 8'hFF, 8'h55, 8'hAA,
            8'h55, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h3C, 8'hC3,
            8'h7E};
        for (int i = 0; i < LIST_CAP; i++) send_item(obls_pkg::OP_APPEND, fill_vals[i]);
        send_item(obls_pkg::OP_APPEND, 8'h99);
        send_item(obls_pkg::OP_DISPLAY, 8'hFF);
    endtask

    // Remove head, first of a duplicate pair and tail; miss once
    task automatic test_delete_cases();
        send_item(obls_pkg::OP_DELETE, 8'h00);
        send_item(obls_pkg::OP_DELETE, 8'h55);
        send_item(obls_pkg::OP_DELETE, 8'h7E);
        send_item(obls_pkg::OP_DELETE, 8'h99);
        send_item(obls_pkg::OP_DISPLAY, 8'h00);
    endtask

    // Alternate fill-heavy and drain-heavy phases so full and empty recur
    task automatic test_random_mix();
        for (int phase = 0; phase < 8; phase++)
            for (int i = 0; i < 18; i++) send_random_item((phase % 2 == 0) ? 65 : 25);
    endtask

    // Back-to-back transfers on both sides
    task automatic test_steady_stream();
        gaps_on <= 1'b0;
        for (int i = 0; i < 40; i++) send_random_item(45);
        gaps_on <= 1'b1;
    endtask

    // Hold the receiver off while the sender keeps offering items
    task automatic test_output_stall();
        stall_requests <= stall_requests + 1;
        send_item(obls_pkg::OP_DISPLAY, 8'h00);
        for (int i = 0; i < 20; i++) send_random_item(50);
    endtask

    // Check each output transfer against the oldest prediction
    always @(posedge i_clk) begin : reply_check
        t_reply want;
        t_reply got;
        if (m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.data   = m_tdata[obls_pkg::DATA_W-1:0];
            got.length = m_tdata[obls_pkg::DATA_W +: obls_pkg::LEN_W];
            got.last   = m_tlast;
            if (awaited_replies.size() == 0) begin
                if (fail_count < 10)
                    $display("[%0t] unexpected reply: status %0d data %02h length %0d last %0b",
                             $realtime, got.status, got.data, got.length, got.last);
                fail_count++;
            end else begin
                want = awaited_replies.pop_front();
                if (got !== want) begin
                    if (fail_count < 10)
                        $display({"[%0t] reply mismatch: expected status %0d data %02h ",
                                  "length %0d last %0b, got status %0d data %02h ",
                                  "length %0d last %0b"}, $realtime,
                                 want.status, want.data, want.length, want.last,
                                 got.status, got.data, got.length, got.last);
                    fail_count++;
                end
            end
        end
    end

    // Drive tready: count down a requested hold-off, otherwise idle at random
    always @(posedge i_clk) begin : ready_drive
        // a new hold-off request restarts the stall count
        if (stall_requests != stall_served) begin
            stall_served <= stall_requests;
            stall_left   <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (gaps_on) begin
            m_tready <= ($urandom_range(0, 99) >= 30);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("ordered_byte_list_store_core verification failed");
        $finish;
    end

    // Test sequence
    initial begin
        i_rst_n        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = obls_pkg::OP_APPEND;
        m_tready       = 1'b0;
        gaps_on        = 1'b1;
        fail_count     = 0;
        stall_requests = 0;
        stall_served   = 0;
        stall_left     = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_fill_to_full();
        test_delete_cases();
        test_random_mix();
        test_steady_stream();
        test_output_stall();

        // drain outstanding replies, then watch for strays
        s_tvalid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("ordered_byte_list_store_core verification clean");
        end else begin
            $display("ordered_byte_list_store_core verification failed");
        end
        $finish;
    end

endmodule
